>>> hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hdl/v2dc_pkg.sv
// constants and types for the streaming 2d convolution
package v2dc_pkg;
  localparam int MaxWidth = 1024;
  localparam int MaxKernel = 7;
  localparam int Taps = MaxKernel * MaxKernel;
  localparam int ColW = $clog2(MaxWidth);
  localparam int PixW = 16;
  localparam int ProdW = 32;
  localparam int SumW = 38;

  typedef enum logic {
    CmdLoad = 1'b0,
    CmdPixel = 1'b1
  } cmd_e;

  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegKernel = 2'd2;

  // control passed down the cell chain with each window
  typedef struct packed {
    logic valid;
    logic [9:0] row;
    logic [9:0] col;
    logic last;
  } tag_t;
endpackage

>>> hdl/valid_2d_convolution_stream.sv
// top level of the streaming valid-mode 2d convolution
// Usage: a single input channel carries transactions of two kinds. command 0
// loads one Q2.14 coefficient at coef_index (row-major, index >= 49 is
// ignored); command 1 delivers one signed 16-bit pixel in raster order.
// Each pixel reads its column of six line buffers (one ram per kernel row
// above the newest), shifts the 7x7 window, and once row and column reach kernel_side-1 a
// result transaction carries the exact sum, output coordinates and an
// end-of-frame flag. The sum runs down a chain of seven row cells, two
// registers each, and then through the output register.
// A pixel blocks the input until its line-buffer write is done; coefficient
// loads are taken one per cycle unless stalled: the line-buffer rams have one
// port, read as the pixel is taken and written in the phase that follows.
// Reset restores 640x480 with kernel side 3, zero coefficients and window,
// and zero counters; line buffers are undefined until a full row is written.
// When the receiver stalls the whole chain freezes and the input stops taking
// transactions until the output register is free again.
// Registers are written through cfg_we_i/cfg_addr_i/cfg_wdata_i; the user must write them only while idle, unenforced.
`include "assert_macros.svh"
module valid_2d_convolution_stream (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [10:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [5:0]         coef_index_i,
  input  logic signed [15:0] coef_value_i,
  input  logic signed [15:0] pixel_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [37:0] conv_sum_o,
  output logic [9:0]         out_row_o,
  output logic [9:0]         out_col_o,
  output logic               frame_last_o
);
  localparam int K = v2dc_pkg::MaxKernel;
  localparam int CW = v2dc_pkg::ColW;

  logic [10:0] width_q, height_q;
  logic [2:0] kside_q;
  logic signed [15:0] kern_q [v2dc_pkg::Taps];
  logic signed [15:0] win_q [K][K];
  logic [9:0] col_q, row_q;
  logic phase_q;
  logic signed [15:0] pix_q;
  logic [10:0] w_eff, h_eff;
  logic [2:0] k_eff;
  logic en;
  logic take;
  logic signed [15:0] lb_rd [K-1];
  logic signed [15:0] column [K];
  v2dc_pkg::tag_t tag_new;
  logic [10:0] col_nx, row_nx;
  logic col_wrap, row_wrap;

  // clamp config
  assign k_eff = (kside_q == 3'd0) ? 3'd1 : kside_q;
  assign w_eff = (width_q == 11'd0) ? 11'd1 :
                 (width_q > 11'(v2dc_pkg::MaxWidth)) ? 11'(v2dc_pkg::MaxWidth) : width_q;
  assign h_eff = (height_q == 11'd0) ? 11'd1 : (height_q > 11'd1024) ? 11'd1024 : height_q;

  // the chain advances unless a finished result waits
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en && !phase_q;
  assign take = in_valid_i && in_ready_o && (command_i == v2dc_pkg::CmdPixel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 11'd640;
      height_q <= 11'd480;
      kside_q <= 3'd3;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        v2dc_pkg::RegWidth:  width_q <= cfg_wdata_i;
        v2dc_pkg::RegHeight: height_q <= cfg_wdata_i;
        v2dc_pkg::RegKernel: kside_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < v2dc_pkg::Taps; t++) kern_q[t] <= '0;
    end else if (in_valid_i && in_ready_o && command_i == v2dc_pkg::CmdLoad
                 && coef_index_i < 6'(v2dc_pkg::Taps)) begin
      kern_q[coef_index_i] <= coef_value_i;
    end
  end

  // line buffers: ram i holds pixel rows feeding window row i
  // col_q holds the pixel's column from the take edge until the write edge
  for (genvar i = 0; i < K - 1; i++) begin : g_lb
    v2dc_ram #(.Width(16), .Depth(v2dc_pkg::MaxWidth)) u_lb (
      .clk_i  (clk_i),
      .we_i   (phase_q && en),
      .addr_i (col_q[CW-1:0]),
      .wdata_i(column[i+1]),
      .rdata_o(lb_rd[i])
    );
    assign column[i] = lb_rd[i];
  end
  assign column[K-1] = pix_q;

  assign col_nx = 11'(col_q) + 11'd1;
  assign row_nx = 11'(row_q) + 11'd1;
  assign col_wrap = col_nx >= w_eff;
  assign row_wrap = row_nx >= h_eff;

  always_comb begin
    tag_new.valid = phase_q && (col_q >= 10'(k_eff - 3'd1)) && (row_q >= 10'(k_eff - 3'd1));
    tag_new.row = row_q - 10'(k_eff - 3'd1);
    tag_new.col = col_q - 10'(k_eff - 3'd1);
    tag_new.last = col_wrap && row_wrap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      col_q <= '0;
      row_q <= '0;
      for (int i = 0; i < K; i++)
        for (int j = 0; j < K; j++) win_q[i][j] <= '0;
    end else if (en) begin
      if (take) begin
        phase_q <= 1'b1;
      end else if (phase_q) begin
        phase_q <= 1'b0;
        for (int i = 0; i < K; i++) begin
          for (int j = 0; j < K - 1; j++) win_q[i][j] <= win_q[i][j+1];
          win_q[i][K-1] <= column[i];
        end
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_wrap ? 10'd0 : row_nx[9:0];
        end else begin
          col_q <= col_nx[9:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pix_q <= pixel_value_i;
    end
  end

  // window snapshot with kernel aligned per row for the cell chain
  logic signed [15:0] wpix [K][K];
  logic signed [15:0] wcoef [K][K];
  always_comb begin
    logic [2:0] base;
    base = 3'(K) - k_eff;
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        if (j < K - 1) wpix[i][j] = win_q[i][j+1];
        else wpix[i][j] = column[i];
        if (3'(i) >= base && 3'(j) >= base)
          wcoef[i][j] = kern_q[6'(3'(i) - base) * 6'(k_eff) + 6'(3'(j) - base)];
        else
          wcoef[i][j] = '0;
      end
    end
  end

  // delay row i through the dpix/dcoef shift registers so each cell sees its row when the sum arrives
  logic signed [15:0] dpix [K][2*K][K];
  logic signed [15:0] dcoef [K][2*K][K];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < K; i++) begin
        dpix[i][0] <= wpix[i];
        dcoef[i][0] <= wcoef[i];
        for (int s = 1; s < 2 * K; s++) begin
          dpix[i][s] <= dpix[i][s-1];
          dcoef[i][s] <= dcoef[i][s-1];
        end
      end
    end
  end

  logic signed [37:0] chain_sum [K+1];
  v2dc_pkg::tag_t chain_tag [K+1];
  assign chain_sum[0] = '0;
  assign chain_tag[0] = tag_new;

  for (genvar i = 0; i < K; i++) begin : g_cell
    logic signed [15:0] cp [K];
    logic signed [15:0] cc [K];
    if (i == 0) begin : g_first
      assign cp = wpix[0];
      assign cc = wcoef[0];
    end else begin : g_rest
      assign cp = dpix[i][2*i-1];
      assign cc = dcoef[i][2*i-1];
    end
    v2dc_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .pix_i (cp),
      .coef_i(cc),
      .sum_i (chain_sum[i]),
      .tag_i (chain_tag[i]),
      .sum_o (chain_sum[i+1]),
      .tag_o (chain_tag[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= chain_tag[K].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      conv_sum_o <= chain_sum[K];
      out_row_o <= chain_tag[K].row;
      out_col_o <= chain_tag[K].col;
      frame_last_o <= chain_tag[K].last;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(conv_sum_o))
  `ASSERT_ALWAYS(a_no_take_in_phase, clk_i, rst_ni, !(phase_q && in_ready_o))
  `ASSERT_NEXT(a_phase_follows, clk_i, rst_ni, take, phase_q)
endmodule

>>> hdl/v2dc_ram.sv
// generic single-port ram with registered read
module v2dc_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> hdl/v2dc_cell.sv
// one kernel-row cell: multiplies its window row and adds to the passing sum
module v2dc_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic signed [v2dc_pkg::PixW-1:0] pix_i [v2dc_pkg::MaxKernel],
  input  logic signed [v2dc_pkg::PixW-1:0] coef_i [v2dc_pkg::MaxKernel],
  input  logic signed [v2dc_pkg::SumW-1:0] sum_i,
  input  v2dc_pkg::tag_t                   tag_i,
  output logic signed [v2dc_pkg::SumW-1:0] sum_o,
  output v2dc_pkg::tag_t                   tag_o
);
  logic signed [v2dc_pkg::ProdW-1:0] prod_q [v2dc_pkg::MaxKernel];
  logic signed [v2dc_pkg::SumW-1:0] sum_q, acc_d, sum_d;
  v2dc_pkg::tag_t tag_q, tag_out_q;

  // stage one registers the products, stage two adds them to the chain sum
  always_comb begin
    acc_d = sum_q;
    for (int j = 0; j < v2dc_pkg::MaxKernel; j++) begin
      acc_d = acc_d + v2dc_pkg::SumW'(prod_q[j]);
    end
    sum_d = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
      tag_out_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
      tag_out_q <= tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < v2dc_pkg::MaxKernel; j++) begin
        prod_q[j] <= pix_i[j] * coef_i[j];
      end
      sum_q <= sum_i;
      sum_o <= sum_d;
    end
  end

  assign tag_o = tag_out_q;
endmodule
